[design/pfcs_pkg.sv]
// ----------------------------------------------------------------------------
// pfcs_pkg
// Shared widths, constants and types for the pressure frame check and scale
// block: CRC-8 settings, status codes and the divider request bundle.
// ----------------------------------------------------------------------------
package pfcs_pkg;

  // crc-8 settings
  localparam logic [7:0] CRC_START = 8'hFF;
  localparam logic [7:0] CRC_POLY  = 8'h31;

  // field and datapath widths
  localparam int WORD_W  = 16;
  localparam int GAIN_W  = 10;
  localparam int DVD_W   = 25;
  localparam int DVS_W   = 17;
  localparam int PRESS_W = 26;
  localparam int CNT_W   = 5;

  localparam logic [GAIN_W-1:0] PRESSURE_GAIN = 10'd1000;

  // status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_CRC  = 2'd1;
  localparam logic [1:0] STATUS_ZERO = 2'd2;

  // byte place within a three-byte group
  localparam logic [1:0] OFF_HIGH = 2'd0;
  localparam logic [1:0] OFF_LOW  = 2'd1;
  localparam logic [1:0] OFF_CRC  = 2'd2;

  // word index within a transfer
  localparam logic [1:0] GRP_READING = 2'd0;
  localparam logic [1:0] GRP_SCALE   = 2'd2;

  // request to the serial divider
  typedef struct packed {
    logic              start;
    logic              neg;
    logic [DVD_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

endpackage

[design/pressure_frame_check_and_scale.sv]
// ----------------------------------------------------------------------------
// pressure_frame_check_and_scale
// Checks the bytes of a sensor read transfer and emits a scaled pressure.
// ----------------------------------------------------------------------------
// One byte is taken per item. Each byte is folded into the CRC-8 bit by bit,
// and after a byte that completes no transfer the next byte is only taken
// once that fold is done. The last byte of a transfer (the third, or the
// ninth while no scale factor is held) yields one result: on a checksum
// failure or a zero scale it is ready as soon as the fold is done, otherwise
// the serial divider works out 25 quotient bits, one per cycle, and then
// hands the quotient over.
// A finished result waits in an output register, so new bytes are accepted
// while it is still pending; a second result waits for that register.
// ----------------------------------------------------------------------------
module pressure_frame_check_and_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_rx_byte,
  input  logic                                in_first_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [pfcs_pkg::PRESS_W-1:0] out_pressure,
  output logic [1:0]                          out_status
);

  localparam int WORD_W  = pfcs_pkg::WORD_W;
  localparam int PRESS_W = pfcs_pkg::PRESS_W;
  localparam int DVD_W   = pfcs_pkg::DVD_W;
  localparam int DVS_W   = pfcs_pkg::DVS_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CRC  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]         state_r;
  logic [1:0]         state_nxt;
  logic [1:0]         grp_r;
  logic [1:0]         off_r;
  logic [7:0]         crc_r;
  logic [7:0]         high_r;
  logic [WORD_W-1:0]  reading_r;
  logic [WORD_W-1:0]  scale_r;
  logic [WORD_W-1:0]  cand_r;
  logic               fail_r;
  logic               fetch_r;
  logic [PRESS_W-1:0] res_p_r;
  logic [1:0]         res_s_r;
  logic               out_valid_r;
  logic [PRESS_W-1:0] out_p_r;
  logic [1:0]         out_s_r;

  logic               in_acc;
  logic               start_new;
  logic [1:0]         grp_eff;
  logic [1:0]         off_eff;
  logic [7:0]         crc_eff;
  logic               crc_busy;
  logic               crc_done;
  logic [7:0]         crc_out;
  logic               is_last;
  logic               fail_upd;
  logic [WORD_W-1:0]  scale_eff;
  logic [WORD_W-1:0]  reading_mag;
  logic [WORD_W-1:0]  scale_mag;
  logic [WORD_W+pfcs_pkg::GAIN_W-1:0] product;
  logic               div_busy;
  logic               div_done;
  logic signed [PRESS_W-1:0] div_quot;
  logic               out_free;
  pfcs_pkg::div_req_t div_req;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // start of a transfer: flagged byte, or any byte at position zero
  always_comb begin
    start_new = in_first_byte || (grp_r == 2'd0 && off_r == pfcs_pkg::OFF_HIGH);
    grp_eff   = start_new ? 2'd0 : grp_r;
    off_eff   = start_new ? pfcs_pkg::OFF_HIGH : off_r;
    crc_eff   = start_new ? pfcs_pkg::CRC_START : crc_r;
  end

  pfcs_crc_serial u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .crc_in  (crc_eff),
    .byte_in (in_rx_byte),
    .busy    (crc_busy),
    .done    (crc_done),
    .crc_out (crc_out)
  );

  // end-of-byte decisions
  always_comb begin
    is_last   = (off_r == pfcs_pkg::OFF_CRC) &&
                (fetch_r ? (grp_r == pfcs_pkg::GRP_SCALE) :
                           (grp_r == pfcs_pkg::GRP_READING));
    fail_upd  = fail_r || ((off_r == pfcs_pkg::OFF_CRC) && (crc_out != 8'h00));
    scale_eff = fetch_r ? cand_r : scale_r;
  end

  // divider operands: magnitudes, gain applied once
  always_comb begin
    reading_mag      = reading_r[WORD_W-1] ? (WORD_W'(0) - reading_r) : reading_r;
    scale_mag        = scale_eff[WORD_W-1] ? (WORD_W'(0) - scale_eff) : scale_eff;
    product          = reading_mag * pfcs_pkg::PRESSURE_GAIN;
    div_req.start    = (state_r == S_CRC) && crc_done && is_last && !fail_upd &&
                       (scale_eff != '0);
    div_req.neg      = reading_r[WORD_W-1] ^ scale_eff[WORD_W-1];
    div_req.dividend = product[DVD_W-1:0];
    div_req.divisor  = DVS_W'(scale_mag);
  end

  pfcs_div_serial u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

  // state sequencing
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_CRC;
        end
      end
      S_CRC: begin
        if (crc_done) begin
          if (!is_last) begin
            state_nxt = S_IDLE;
          end else if (div_req.start) begin
            state_nxt = S_DIV;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      grp_r       <= 2'd0;
      off_r       <= pfcs_pkg::OFF_HIGH;
      crc_r       <= pfcs_pkg::CRC_START;
      scale_r     <= '0;
      fail_r      <= 1'b0;
      fetch_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // byte taken
      if (in_acc) begin
        grp_r <= grp_eff;
        off_r <= off_eff;
        if (start_new) begin
          fail_r  <= 1'b0;
          fetch_r <= (scale_r == '0);
        end
      end
      // byte folded into the crc
      if (state_r == S_CRC && crc_done) begin
        fail_r <= fail_upd;
        crc_r  <= (off_r == pfcs_pkg::OFF_CRC) ? pfcs_pkg::CRC_START : crc_out;
        if (is_last) begin
          grp_r <= 2'd0;
          off_r <= pfcs_pkg::OFF_HIGH;
          if (!fail_upd && fetch_r) begin
            scale_r <= cand_r;
          end
        end else if (off_r == pfcs_pkg::OFF_CRC) begin
          grp_r <= grp_r + 2'd1;
          off_r <= pfcs_pkg::OFF_HIGH;
        end else begin
          off_r <= off_r + 2'd1;
        end
      end
      // output register
      if (state_r == S_EMIT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // data words and results
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (off_eff == pfcs_pkg::OFF_HIGH) begin
        high_r <= in_rx_byte;
      end else if (off_eff == pfcs_pkg::OFF_LOW) begin
        if (grp_eff == pfcs_pkg::GRP_READING) begin
          reading_r <= {high_r, in_rx_byte};
        end else if (grp_eff == pfcs_pkg::GRP_SCALE) begin
          cand_r <= {high_r, in_rx_byte};
        end
      end
    end
    if (state_r == S_CRC && crc_done && is_last) begin
      res_p_r <= '0;
      res_s_r <= fail_upd ? pfcs_pkg::STATUS_CRC : pfcs_pkg::STATUS_ZERO;
    end
    if (state_r == S_DIV && div_done) begin
      res_p_r <= div_quot;
      res_s_r <= pfcs_pkg::STATUS_OK;
    end
    if (state_r == S_EMIT && out_free) begin
      out_p_r <= res_p_r;
      out_s_r <= res_s_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pressure = out_p_r;
  assign out_status   = out_s_r;

`ifndef NO_ASSERTIONS
  // the crc unit only runs while a byte is in flight
  a_crc_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    crc_busy |-> (state_r == S_CRC))
    else $error("crc unit busy outside byte processing");

  // the divider only runs in its own phase
  a_div_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == S_DIV))
    else $error("divider busy outside divide phase");

  // an accepted item always starts a crc pass
  a_accept_crc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (crc_busy && state_r == S_CRC))
    else $error("accepted item did not start crc");

  // an error status carries zero pressure
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != pfcs_pkg::STATUS_OK) |-> (out_pressure == '0))
    else $error("error result with non-zero pressure");
`endif

endmodule

[design/pfcs_crc_serial.sv]
// ----------------------------------------------------------------------------
// pfcs_crc_serial
// Bit-serial CRC-8 update: folds one byte into a running CRC, MSB first,
// one bit per clock until all eight bits are folded in.
// ----------------------------------------------------------------------------
module pfcs_crc_serial (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] crc_in,
  input  logic [7:0] byte_in,
  output logic       busy,
  output logic       done,
  output logic [7:0] crc_out
);

  logic [7:0] crc_r;
  logic [2:0] cnt_r;
  logic       busy_r;
  logic       done_r;
  logic [7:0] crc_nxt;

  // one polynomial step
  always_comb begin
    if (crc_r[7]) begin
      crc_nxt = {crc_r[6:0], 1'b0} ^ pfcs_pkg::CRC_POLY;
    end else begin
      crc_nxt = {crc_r[6:0], 1'b0};
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 3'd0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift register
  always_ff @(posedge clk) begin
    if (start) begin
      crc_r <= crc_in ^ byte_in;
    end else if (busy_r) begin
      crc_r <= crc_nxt;
    end
  end

  assign busy    = busy_r;
  assign done    = done_r;
  assign crc_out = crc_r;

endmodule

[design/pfcs_div_serial.sv]
// ----------------------------------------------------------------------------
// pfcs_div_serial
// Restoring divider on magnitudes, one quotient bit per clock, with the
// sign applied to the quotient at the output.
// ----------------------------------------------------------------------------
module pfcs_div_serial (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pfcs_pkg::div_req_t                  req,
  output logic                                busy,
  output logic                                done,
  output logic signed [pfcs_pkg::PRESS_W-1:0] quot
);

  localparam int DVD_W = pfcs_pkg::DVD_W;
  localparam int DVS_W = pfcs_pkg::DVS_W;
  localparam int CNT_W = pfcs_pkg::CNT_W;

  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             neg_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   shifted;
  logic [DVS_W+1:0] diff;
  logic             borrow;

  // trial subtract
  always_comb begin
    shifted = {rem_r, dvd_r[DVD_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_r};
    borrow  = diff[DVS_W+1];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dvs_r <= req.divisor;
      neg_r <= req.neg;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], ~borrow};
      rem_r <= borrow ? shifted[DVS_W-1:0] : diff[DVS_W-1:0];
    end
  end

  // signed result
  always_comb begin
    if (neg_r) begin
      quot = pfcs_pkg::PRESS_W'(0) - pfcs_pkg::PRESS_W'({1'b0, dvd_r});
    end else begin
      quot = pfcs_pkg::PRESS_W'({1'b0, dvd_r});
    end
  end

  assign busy = busy_r;
  assign done = done_r;

endmodule
